// ===== rtl/pidis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidis_pkg
// Shared types and constants for the PID unit with integral separation.
// ----------------------------------------------------------------------------
package pidis_pkg;

    // Default width of every signed Q8.16 value (setpoint, limits, measured, drive)
    localparam int VALUE_WIDTH_DEF = 24;

    // Fixed field widths
    localparam int GAIN_W     = 18;   // unsigned Q2.16 gains
    localparam int BAND_W     = 23;   // unsigned separation band
    localparam int SUM_W      = 32;   // signed running error sum
    localparam int FRAC_BITS  = 16;   // fraction bits dropped after each product
    localparam int CMP_W      = 33;   // band compare width, covers values up to 32 bits
    localparam int CFG_IDX_W  = 3;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_UPPER    = 3'd4,
        REG_LOWER    = 3'd5,
        REG_BAND     = 3'd6
    } cfg_index_t;

    // Reset values
    localparam int SETPOINT_RST = 163840;   // 2.5
    localparam int GAIN_P_RST   = 6554;     // 0.1
    localparam int GAIN_I_RST   = 688;      // 0.0105
    localparam int GAIN_D_RST   = 1311;     // 0.02
    localparam int UPPER_RST    = 655360;   // 10.0
    localparam int LOWER_RST    = 0;
    localparam int BAND_RST     = 13107;    // 0.2

    // Gains and separation band, fixed-width part of the register set
    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [BAND_W-1:0] band;
    } gains_t;

endpackage

// ===== rtl/pidis_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidis_cfg_regs
// Configuration register file: decodes index/data writes into the setpoint,
// the integration limits, the three gains and the separation band.
// ----------------------------------------------------------------------------
module pidis_cfg_regs #(
    parameter int VALUE_WIDTH = pidis_pkg::VALUE_WIDTH_DEF,
    parameter int CFG_DATA_W  = pidis_pkg::BAND_W
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pidis_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data,
    output logic signed [VALUE_WIDTH-1:0]        setpoint,
    output logic signed [VALUE_WIDTH-1:0]        upper_limit,
    output logic signed [VALUE_WIDTH-1:0]        lower_limit,
    output pidis_pkg::gains_t                    gains
);

    logic signed [VALUE_WIDTH-1:0] setpoint_reg, setpoint_next;
    logic signed [VALUE_WIDTH-1:0] upper_reg, upper_next;
    logic signed [VALUE_WIDTH-1:0] lower_reg, lower_next;
    pidis_pkg::gains_t             gains_reg, gains_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register decode, unknown indexes are dropped
    always_comb begin
        setpoint_next = setpoint_reg;
        upper_next    = upper_reg;
        lower_next    = lower_reg;
        gains_next    = gains_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pidis_pkg::REG_SETPOINT: setpoint_next = cfg_data[VALUE_WIDTH-1:0];
                pidis_pkg::REG_GAIN_P:   gains_next.gain_p = cfg_data[pidis_pkg::GAIN_W-1:0];
                pidis_pkg::REG_GAIN_I:   gains_next.gain_i = cfg_data[pidis_pkg::GAIN_W-1:0];
                pidis_pkg::REG_GAIN_D:   gains_next.gain_d = cfg_data[pidis_pkg::GAIN_W-1:0];
                pidis_pkg::REG_UPPER:    upper_next = cfg_data[VALUE_WIDTH-1:0];
                pidis_pkg::REG_LOWER:    lower_next = cfg_data[VALUE_WIDTH-1:0];
                pidis_pkg::REG_BAND:     gains_next.band = cfg_data[pidis_pkg::BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg     <= VALUE_WIDTH'(pidis_pkg::SETPOINT_RST);
            upper_reg        <= VALUE_WIDTH'(pidis_pkg::UPPER_RST);
            lower_reg        <= VALUE_WIDTH'(pidis_pkg::LOWER_RST);
            gains_reg.gain_p <= pidis_pkg::GAIN_W'(pidis_pkg::GAIN_P_RST);
            gains_reg.gain_i <= pidis_pkg::GAIN_W'(pidis_pkg::GAIN_I_RST);
            gains_reg.gain_d <= pidis_pkg::GAIN_W'(pidis_pkg::GAIN_D_RST);
            gains_reg.band   <= pidis_pkg::BAND_W'(pidis_pkg::BAND_RST);
        end else begin
            setpoint_reg <= setpoint_next;
            upper_reg    <= upper_next;
            lower_reg    <= lower_next;
            gains_reg    <= gains_next;
        end
    end

    assign setpoint    = setpoint_reg;
    assign upper_limit = upper_reg;
    assign lower_limit = lower_reg;
    assign gains       = gains_reg;

endmodule

// ===== rtl/pid_integral_separation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_integral_separation_unit
// Positional PID controller with integral separation on signed Q8.16 values.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel : one measured value per word. m_ channel : one word per input,
//   drive in m_tdata, integral_on in m_tuser.
//   cfg channel: index/data register writes, always ready; write only while
//   no word is in flight.
//   Path: from input acceptance to m_tvalid a word passes the error/sum
//   stage, product stage and sum-and-clamp stage into the output register.
//   Throughput: one word per cycle unless the receiver stalls. The running sum and previous error are
//   updated in the first stage, so consecutive words need no gap.
//   Reset (aresetn low, synchronous): pipeline emptied, error sum and previous
//   error cleared, registers back to their defaults.
//   Receiver stall: words hold in the output register; the pipeline keeps
//   taking input until each stage is full, then s_tready drops.
// ----------------------------------------------------------------------------
module pid_integral_separation_unit #(
    parameter int VALUE_WIDTH = pidis_pkg::VALUE_WIDTH_DEF,
    localparam int S_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int CFG_DATA_W = (VALUE_WIDTH > pidis_pkg::BAND_W) ? VALUE_WIDTH
                                                                    : pidis_pkg::BAND_W
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // measured value
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,   // [VALUE_WIDTH-1:0] measured
    // result
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [S_TDATA_W-1:0]             m_tdata,   // [VALUE_WIDTH-1:0] drive
    output logic [0:0]                       m_tuser,   // [0] integral_on
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pidis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data
);

    localparam int W      = VALUE_WIDTH;
    localparam int FRAC   = pidis_pkg::FRAC_BITS;
    localparam int SUM_W  = pidis_pkg::SUM_W;
    localparam int GS_W   = pidis_pkg::GAIN_W + 1;
    localparam int PP_W   = W + GS_W;
    localparam int PI_W   = SUM_W + GS_W;
    localparam int PD_W   = W + 1 + GS_W;
    localparam int TP_W   = PP_W - FRAC;
    localparam int TI_W   = PI_W - FRAC;
    localparam int TD_W   = PD_W - FRAC;
    localparam int ACC_W  = ((TD_W > TI_W) ? TD_W : TI_W) + 2;

    // Configuration
    logic signed [W-1:0] setpoint;
    logic signed [W-1:0] upper_limit;
    logic signed [W-1:0] lower_limit;
    pidis_pkg::gains_t   gains;

    pidis_cfg_regs #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .CFG_DATA_W  (CFG_DATA_W)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .setpoint    (setpoint),
        .upper_limit (upper_limit),
        .lower_limit (lower_limit),
        .gains       (gains)
    );

    // Saturation bounds
    logic signed [W-1:0]     val_max;
    logic signed [W-1:0]     val_min;
    logic signed [SUM_W-1:0] sum_max;
    logic signed [SUM_W-1:0] sum_min;
    assign val_max = {1'b0, {(W-1){1'b1}}};
    assign val_min = {1'b1, {(W-1){1'b0}}};
    assign sum_max = {1'b0, {(SUM_W-1){1'b1}}};
    assign sum_min = {1'b1, {(SUM_W-1){1'b0}}};

    // Pipeline occupancy and flow control
    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic open1, open2, open3, in_fire;

    assign open3    = !v3_reg || m_tready;
    assign open2    = !v2_reg || open3;
    assign open1    = !v1_reg || open2;
    assign s_tready = open1;
    assign in_fire  = s_tvalid && open1;

    assign v1_next = in_fire || (v1_reg && !open2);
    assign v2_next = open2 ? v1_reg : v2_reg;
    assign v3_next = open3 ? v2_reg : v3_reg;

    // Stage 1: error, separation test, sum update
    logic signed [W-1:0]     meas;
    logic signed [W:0]       diff;
    logic signed [W-1:0]     err;
    logic [W:0]              err_ext;
    logic [W:0]              mag;
    logic                    on;
    logic                    take;
    logic signed [SUM_W:0]   sum_add;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [SUM_W-1:0] sum_used;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [W-1:0]     prev_reg, prev_next;
    logic signed [W:0]       delta;

    always_comb begin
        meas    = s_tdata[W-1:0];
        diff    = (W+1)'(setpoint) - (W+1)'(meas);
        if (diff[W] != diff[W-1]) begin
            err = diff[W] ? val_min : val_max;
        end else begin
            err = diff[W-1:0];
        end
        err_ext = {err[W-1], err};
        mag     = err[W-1] ? (W+1)'(-err_ext) : err_ext;
        on      = pidis_pkg::CMP_W'(mag) <= pidis_pkg::CMP_W'(gains.band);
        // upper limit rule wins when the limits are crossed
        if (meas > upper_limit) begin
            take = err[W-1];
        end else if (meas < lower_limit) begin
            take = !err[W-1] && (err != '0);
        end else begin
            take = 1'b1;
        end
        sum_add = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(err);
        if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
            sum_sat = sum_add[SUM_W] ? sum_min : sum_max;
        end else begin
            sum_sat = sum_add[SUM_W-1:0];
        end
        sum_used  = (on && take) ? sum_sat : sum_reg;
        delta     = (W+1)'(err) - (W+1)'(prev_reg);
        sum_next  = in_fire ? sum_used : sum_reg;
        prev_next = in_fire ? err : prev_reg;
    end

    logic signed [W-1:0]     e1_reg;
    logic signed [W:0]       d1_reg;
    logic signed [SUM_W-1:0] s1_reg;
    logic                    on1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end else begin
            sum_reg  <= sum_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            e1_reg  <= err;
            d1_reg  <= delta;
            s1_reg  <= sum_used;
            on1_reg <= on;
        end
    end

    // Stage 2: the three gain products, scaled down by 2^16; the integral term is zero outside the band
    logic signed [GS_W-1:0] gp_s, gi_s, gd_s;
    logic signed [PP_W-1:0] prod_p;
    logic signed [PI_W-1:0] prod_i;
    logic signed [PD_W-1:0] prod_d;
    logic signed [TI_W-1:0] term_i;

    always_comb begin
        gp_s   = {1'b0, gains.gain_p};
        gi_s   = {1'b0, gains.gain_i};
        gd_s   = {1'b0, gains.gain_d};
        prod_p = PP_W'(gp_s) * PP_W'(e1_reg);
        prod_i = PI_W'(gi_s) * PI_W'(s1_reg);
        prod_d = PD_W'(gd_s) * PD_W'(d1_reg);
        term_i = on1_reg ? prod_i[PI_W-1:FRAC] : '0;
    end

    logic signed [TP_W-1:0] tp2_reg;
    logic signed [TI_W-1:0] ti2_reg;
    logic signed [TD_W-1:0] td2_reg;
    logic                   on2_reg;

    always_ff @(posedge aclk) begin
        if (open2) begin
            tp2_reg <= prod_p[PP_W-1:FRAC];
            ti2_reg <= term_i;
            td2_reg <= prod_d[PD_W-1:FRAC];
            on2_reg <= on1_reg;
        end
    end

    // Stage 3: sum of setpoint and terms, and output clamp
    logic signed [ACC_W-1:0] acc;
    logic signed [W-1:0]     drive;

    always_comb begin
        acc = ACC_W'(setpoint) + ACC_W'(tp2_reg) + ACC_W'(ti2_reg) + ACC_W'(td2_reg);
        if (acc > ACC_W'(val_max)) begin
            drive = val_max;
        end else if (acc < ACC_W'(val_min)) begin
            drive = val_min;
        end else begin
            drive = acc[W-1:0];
        end
    end

    logic [W-1:0] drive_reg;
    logic         on3_reg;

    always_ff @(posedge aclk) begin
        if (open3) begin
            drive_reg <= drive;
            on3_reg   <= on2_reg;
        end
    end

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = S_TDATA_W'(drive_reg);
    assign m_tuser  = on3_reg;

endmodule

// ===== rtl/pidis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidis_checker
// Port-level checks for the PID unit, bound to the top level.
// ----------------------------------------------------------------------------
module pidis_checker #(
    parameter int VALUE_WIDTH = pidis_pkg::VALUE_WIDTH_DEF,
    localparam int S_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [S_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // Stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A draining receiver never back-pressures the input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // An empty output register leaves the input open
    a_empty_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with output register empty");

    // An accepted word never leaves the input blocked with no result pending
    a_input_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s_tready || m_tvalid)
        else $error("pipeline blocked with no result pending");

endmodule

bind pid_integral_separation_unit pidis_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pidis_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
